>>> rtl/dcsl_pkg.sv
// Package for the DC shift with peak limiter: widths, register indexes, saturation bounds.
package dcsl_pkg;

	parameter int SAMPLE_BITS = 32;

	parameter int CFG_DATA_W  = 48;
	parameter int CFG_INDEX_W = 3;
	parameter int IPART_W     = 50;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DC_OFFSET       = 3'd0,
		REG_LIMITER_ENABLE  = 3'd1,
		REG_LIMIT_THRESHOLD = 3'd2,
		REG_LIMITER_SLOPE   = 3'd3,
		REG_SHIFT_FRACTION  = 3'd4
	} cfg_reg_t;

	parameter logic signed [IPART_W-1:0] SAT_MAX =
		(IPART_W'(1) <<< (SAMPLE_BITS - 1)) - IPART_W'(1);
	parameter logic signed [IPART_W-1:0] SAT_MIN = -SAT_MAX - IPART_W'(1);

endpackage

>>> rtl/dcsl_ifs.sv
// Valid/ready channel interfaces for the sample input and the result output.
interface dcsl_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface dcsl_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_out;
	logic               was_limited;
	logic               was_clipped;
	logic        [31:0] processed_total;
	logic        [31:0] limited_total;
	logic        [31:0] clipped_total;

	modport source (output valid, output sample_out, output was_limited, output was_clipped,
		output processed_total, output limited_total, output clipped_total, input ready);
	modport sink   (input valid, input sample_out, input was_limited, input was_clipped,
		input processed_total, input limited_total, input clipped_total, output ready);
endinterface

>>> rtl/dc_shift_with_peak_limiter.sv
// Top level of the DC shift with peak limiter: config registers, three-stage datapath, counters.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    sample_in (s32)
//  out_ch    out  valid/ready    sample_out (s32), was_limited, was_clipped,
//                                processed_total, limited_total, clipped_total (u32 each)
//  cfg       in   cfg_wr_en      cfg_index (3b), cfg_data (48b), no read-back
//
//  One request is accepted per cycle while in_ch.ready is high; each request passes through
//  the input register, multiplier register and result register in order.
//  The two slope multiplies (32x16 and 32x32) set the first stage; the wide add,
//  fraction carry and saturation set the second.
//  Reset (arst_n low) clears all valid bits and counters and loads config defaults.
//  A stall on out_ch fills the empty stages first; in_ch.ready drops only when all
//  three stages hold a request.
module dc_shift_with_peak_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	dcsl_in_if.sink                             in_ch,
	dcsl_out_if.source                          out_ch,
	input  logic                                cfg_wr_en,
	input  logic [dcsl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dcsl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW = dcsl_pkg::IPART_W;

	// Configuration registers
	logic signed [32:0] dc_offset_q;
	logic               lim_en_q;
	logic        [30:0] thr_q;
	logic        [47:0] slope_q;
	logic signed [31:0] sf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q <= '0;
			lim_en_q    <= 1'b0;
			thr_q       <= 31'h7FFF_FFFF;
			slope_q     <= '0;
			sf_q        <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dcsl_pkg::REG_DC_OFFSET:       dc_offset_q <= cfg_data[32:0];
				dcsl_pkg::REG_LIMITER_ENABLE:  lim_en_q    <= cfg_data[0];
				dcsl_pkg::REG_LIMIT_THRESHOLD: thr_q       <= cfg_data[30:0];
				dcsl_pkg::REG_LIMITER_SLOPE:   slope_q     <= cfg_data[47:0];
				dcsl_pkg::REG_SHIFT_FRACTION:  sf_q        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Stage enables: each stage loads when it is empty or its successor moves on
	logic valid_s1, valid_s2, out_valid_q;
	logic adv_out, load_s2, load_s1;

	assign adv_out     = !out_valid_q || out_ch.ready;
	assign load_s2     = !valid_s2 || adv_out;
	assign load_s1     = !valid_s1 || load_s2;
	assign in_ch.ready = load_s1;

	// Stage 1: input register
	logic signed [31:0] sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_ch.valid) begin
			sample_s1 <= in_ch.sample_in;
		end
	end

	// Pick the path, form the magnitude past the threshold, multiply by the slope
	logic signed [33:0] s_ext, thr_ext, pos_m, neg_m, plain_sum;
	logic               sf_pos, sf_neg, pos_hit, neg_hit;
	logic        [31:0] mag;
	logic        [47:0] prod_hi;
	logic        [63:0] prod_lo;

	always_comb begin
		s_ext     = {{2{sample_s1[31]}}, sample_s1};
		thr_ext   = {3'b000, thr_q};
		pos_m     = s_ext - thr_ext;
		neg_m     = -s_ext - thr_ext;
		plain_sum = s_ext + {dc_offset_q[32], dc_offset_q};
		sf_pos    = !sf_q[31] && (sf_q != 32'sd0);
		sf_neg    = sf_q[31];
		pos_hit   = lim_en_q && (s_ext > thr_ext) && sf_pos;
		neg_hit   = lim_en_q && (s_ext < -thr_ext) && sf_neg && !pos_hit;
		mag       = neg_hit ? neg_m[31:0] : pos_m[31:0];
		prod_hi   = 48'(mag) * 48'(slope_q[47:32]);
		prod_lo   = 64'(mag) * 64'(slope_q[31:0]);
	end

	// Stage 2: product register
	logic               pos_s2, neg_s2, en_s2;
	logic        [47:0] hi_s2;
	logic        [63:0] lo_s2;
	logic signed [33:0] plain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			pos_s2   <= pos_hit;
			neg_s2   <= neg_hit;
			en_s2    <= lim_en_q;
			hi_s2    <= prod_hi;
			lo_s2    <= prod_lo;
			plain_s2 <= plain_sum;
		end
	end

	// Combine integer and fraction parts, add the raw shift, truncate and saturate
	logic        [47:0]    p_int;
	logic        [31:0]    p_frac, q_frac;
	logic                  p_frac_nz;
	logic signed [IW-1:0]  ip0, ip, q_int, thr_w, res_w;
	logic        [32:0]    fp0, fsum;
	logic        [31:0]    frac;
	logic                  limited, clipped;

	always_comb begin
		p_int     = hi_s2 + {16'h0000, lo_s2[63:32]};
		p_frac    = lo_s2[31:0];
		p_frac_nz = (p_frac != 32'h0);
		thr_w     = {{(IW-31){1'b0}}, thr_q};
		q_frac    = {sf_q[29:0], 2'b00};
		q_int     = {{(IW-2){sf_q[31]}}, sf_q[31:30]};
		limited   = pos_s2 || neg_s2;
		if (neg_s2) begin
			ip0 = -{{(IW-48){1'b0}}, p_int} - IW'(p_frac_nz) - thr_w;
			fp0 = {1'b0, -p_frac};
		end else begin
			ip0 = {{(IW-48){1'b0}}, p_int} + thr_w;
			fp0 = {1'b0, p_frac};
		end
		fsum = fp0 + {1'b0, q_frac};
		if (limited) begin
			ip   = ip0 + q_int + IW'(fsum[32]);
			frac = fsum[31:0];
		end else begin
			ip   = {{(IW-34){plain_s2[33]}}, plain_s2};
			frac = '0;
		end
		clipped = 1'b0;
		if (ip > dcsl_pkg::SAT_MAX || (ip == dcsl_pkg::SAT_MAX && frac != 32'h0)) begin
			res_w   = dcsl_pkg::SAT_MAX;
			clipped = 1'b1;
		end else if (ip < dcsl_pkg::SAT_MIN) begin
			res_w   = dcsl_pkg::SAT_MIN;
			clipped = 1'b1;
		end else if (ip[IW-1] && frac != 32'h0) begin
			res_w = ip + IW'(1);
		end else begin
			res_w = ip;
		end
	end

	// Result register and saturating counters; the counters hold while the
	// result waits, so they double as the reported totals
	logic signed [31:0] sample_out_q;
	logic               limited_q, clipped_q;
	logic        [31:0] processed_cnt_q, limited_cnt_q, clipped_cnt_q;
	logic               take;

	assign take = adv_out && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			processed_cnt_q <= '0;
			limited_cnt_q   <= '0;
			clipped_cnt_q   <= '0;
		end else begin
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
			if (take) begin
				processed_cnt_q <= processed_cnt_q
					+ 32'(en_s2 && (processed_cnt_q != 32'hFFFF_FFFF));
				limited_cnt_q   <= limited_cnt_q
					+ 32'(limited && (limited_cnt_q != 32'hFFFF_FFFF));
				clipped_cnt_q   <= clipped_cnt_q
					+ 32'(clipped && (clipped_cnt_q != 32'hFFFF_FFFF));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_out_q <= res_w[31:0];
			limited_q    <= limited;
			clipped_q    <= clipped;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.sample_out      = sample_out_q;
	assign out_ch.was_limited     = limited_q;
	assign out_ch.was_clipped     = clipped_q;
	assign out_ch.processed_total = processed_cnt_q;
	assign out_ch.limited_total   = limited_cnt_q;
	assign out_ch.clipped_total   = clipped_cnt_q;

endmodule

>>> tb/sv/dc_shift_with_peak_limiter_tb.sv
// Self-checking testbench for the DC shift with peak limiter: directed and random samples.
module dc_shift_with_peak_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Output saturation bounds follow SAMPLE_BITS; the input is always a full 32-bit sample.
	localparam longint OUT_MAX = (longint'(1) << (dcsl_pkg::SAMPLE_BITS - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam longint IN_MAX  = 64'sd2147483647;
	localparam longint IN_MIN  = -IN_MAX - 1;
	localparam longint OFFSET_BOUND = 64'sd4294967294;
	localparam longint unsigned LOW32   = 64'hFFFF_FFFF;
	localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
	localparam longint unsigned SLOPE_MAX = 64'hFFFF_FFFF_FFFF;
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_REQUESTS = 92;

	typedef struct packed {
		logic signed [31:0] sample_out;
		logic               was_limited;
		logic               was_clipped;
		logic        [31:0] processed_total;
		logic        [31:0] limited_total;
		logic        [31:0] clipped_total;
	} limiter_result_t;

	// Scoreboard: tracks register shadows and the three counters, predicts each result
	// on request accept and checks results in order.
	class limiter_scoreboard;
		longint          dc_off;
		bit              lim_on;
		longint          thr_q;
		longint unsigned slope_q;
		longint          shift_frac;
		logic [31:0]     n_processed;
		logic [31:0]     n_limited;
		logic [31:0]     n_clipped;
		limiter_result_t expected[$];
		int              failures;

		function new();
			dc_off = 0;
			lim_on = 1'b0;
			thr_q = IN_MAX;
			slope_q = 0;
			shift_frac = 0;
			n_processed = '0;
			n_limited = '0;
			n_clipped = '0;
			failures = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Mirror one register write; bits above a register's width and spare indexes drop out.
		function void set_reg(logic [dcsl_pkg::CFG_INDEX_W-1:0] idx,
				logic [dcsl_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				dcsl_pkg::REG_DC_OFFSET:       dc_off = $signed(data[32:0]);
				dcsl_pkg::REG_LIMITER_ENABLE:  lim_on = data[0];
				dcsl_pkg::REG_LIMIT_THRESHOLD: thr_q = longint'(data[30:0]);
				dcsl_pkg::REG_LIMITER_SLOPE:   slope_q = longint'(data[47:0]);
				dcsl_pkg::REG_SHIFT_FRACTION:  shift_frac = $signed(data[31:0]);
				default: ;
			endcase
		endfunction

		function logic [31:0] bump(logic [31:0] c);
			return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
		endfunction

		// Magnitude times Q16.32 slope, split into integer part and Q.32 fraction.
		function void slope_mul(input longint unsigned m, output longint unsigned ip_u,
				output longint unsigned fp_u);
			longint unsigned lo;
			lo = m * (slope_q & LOW32);
			ip_u = m * (slope_q >> 32) + (lo >> 32);
			fp_u = lo & LOW32;
		endfunction

		function void note_sample(logic signed [31:0] sample_in);
			longint          s;
			longint          ip;
			longint          q;
			longint          res;
			longint unsigned pi;
			longint unsigned pf;
			longint unsigned fp;
			bit              lim;
			bit              clp;
			limiter_result_t r;
			s = sample_in;
			fp = 0;
			lim = 1'b0;
			clp = 1'b0;
			if (lim_on) begin
				n_processed = bump(n_processed);
				if (s > thr_q && shift_frac > 0) begin
					slope_mul(s - thr_q, pi, pf);
					ip = longint'(pi) + thr_q;
					fp = pf;
					lim = 1'b1;
				end else if (s < -thr_q && shift_frac < 0) begin
					// Negate the product; borrow from the integer part when a fraction is left.
					slope_mul(-(s + thr_q), pi, pf);
					ip = -longint'(pi);
					if (pf != 0) begin
						ip = ip - 1;
						fp = ONE_Q32 - pf;
					end
					ip = ip - thr_q;
					lim = 1'b1;
				end else begin
					ip = s + dc_off;
				end
				if (lim) begin
					// Add the raw Q2.30 shift, rescaled to Q.32, with carry out of the fraction.
					q = shift_frac * 4;
					fp = fp + (longint'(q) & LOW32);
					ip = ip + (q >>> 32) + longint'(fp >> 32);
					fp = fp & LOW32;
					n_limited = bump(n_limited);
				end
			end else begin
				ip = s + dc_off;
			end
			if (ip > OUT_MAX || (ip == OUT_MAX && fp != 0)) begin
				res = OUT_MAX;
				clp = 1'b1;
			end else if (ip < OUT_MIN) begin
				res = OUT_MIN;
				clp = 1'b1;
			end else begin
				res = (ip < 0 && fp != 0) ? ip + 1 : ip;
			end
			if (clp)
				n_clipped = bump(n_clipped);
			r.sample_out = res[31:0];
			r.was_limited = lim;
			r.was_clipped = clp;
			r.processed_total = n_processed;
			r.limited_total = n_limited;
			r.clipped_total = n_clipped;
			expected.push_back(r);
		endfunction

		function void report(string field, longint unsigned exp_v, longint unsigned got_v);
			failures++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v,
				got_v);
		endfunction

		function void check_result(limiter_result_t got);
			limiter_result_t want;
			if (expected.size() == 0) begin
				failures++;
				$display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
				return;
			end
			want = expected.pop_front();
			if (got.sample_out !== want.sample_out)
				report("sample_out", want.sample_out, got.sample_out);
			if (got.was_limited !== want.was_limited)
				report("was_limited", want.was_limited, got.was_limited);
			if (got.was_clipped !== want.was_clipped)
				report("was_clipped", want.was_clipped, got.was_clipped);
			if (got.processed_total !== want.processed_total)
				report("processed_total", want.processed_total, got.processed_total);
			if (got.limited_total !== want.limited_total)
				report("limited_total", want.limited_total, got.limited_total);
			if (got.clipped_total !== want.clipped_total)
				report("clipped_total", want.clipped_total, got.clipped_total);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [dcsl_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [dcsl_pkg::CFG_DATA_W-1:0]  cfg_data;

	dcsl_in_if  in_ch();
	dcsl_out_if out_ch();

	limiter_scoreboard sb = new();

	int src_idle_pct;
	int sink_stall_pct;
	int quiet_cycles = 0;

	dc_shift_with_peak_limiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: check every accepted result, then pick the next cycle's ready.
	initial begin
		limiter_result_t got;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.sample_out = out_ch.sample_out;
				got.was_limited = out_ch.was_limited;
				got.was_clipped = out_ch.was_clipped;
				got.processed_total = out_ch.processed_total;
				got.limited_total = out_ch.limited_total;
				got.clipped_total = out_ch.clipped_total;
				sb.check_result(got);
			end
			out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Watchdog: end the run when neither channel moves a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample request after a random idle gap; hold valid high after accept so
	// back-to-back requests see no bubble.
	task automatic push_sample(input logic signed [31:0] value);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_sample(value);
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Leave write enable high; the caller drops it after the last write.
	task automatic write_reg(input logic [dcsl_pkg::CFG_INDEX_W-1:0] idx,
			input logic [dcsl_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Fill the bits above a register's width with noise; the block must drop them.
	function automatic logic [dcsl_pkg::CFG_DATA_W-1:0] pad_field(longint unsigned value,
			int width);
		longint unsigned mask;
		mask = (64'd1 << width) - 1;
		return dcsl_pkg::CFG_DATA_W'(({$urandom, $urandom} & ~mask) | (value & mask));
	endfunction

	// Drain, then write all five registers and every spare index.
	task automatic apply_settings(input longint off, input bit en, input longint thr,
			input longint unsigned slope, input longint frac);
		drain_results();
		write_reg(dcsl_pkg::REG_DC_OFFSET, pad_field(off, 33));
		write_reg(dcsl_pkg::REG_LIMITER_ENABLE, pad_field(en, 1));
		write_reg(dcsl_pkg::REG_LIMIT_THRESHOLD, pad_field(thr, 31));
		write_reg(dcsl_pkg::REG_LIMITER_SLOPE, pad_field(slope, 48));
		write_reg(dcsl_pkg::REG_SHIFT_FRACTION, pad_field(frac, 32));
		for (int i = dcsl_pkg::REG_SHIFT_FRACTION + 1; i < 2 ** dcsl_pkg::CFG_INDEX_W; i++)
			write_reg(dcsl_pkg::CFG_INDEX_W'(i), dcsl_pkg::CFG_DATA_W'({$urandom, $urandom}));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic randomize_settings();
		longint          off;
		longint          thr;
		longint          frac;
		longint unsigned slope;
		case ($urandom_range(0, 3))
			0: off = $signed(16'($urandom));
			1: off = OFFSET_BOUND;
			2: off = -OFFSET_BOUND;
			default: begin
				off = longint'($urandom);
				if (off > OFFSET_BOUND)
					off = OFFSET_BOUND;
				if ($urandom_range(0, 1))
					off = -off;
			end
		endcase
		case ($urandom_range(0, 3))
			0: thr = 0;
			1: thr = IN_MAX;
			2: thr = longint'($urandom_range(32'h2000_0000, 32'h7FFF_FFFF));
			default: thr = longint'($urandom & 32'h7FFF_FFFF);
		endcase
		case ($urandom_range(0, 4))
			0: slope = 0;
			1: slope = SLOPE_MAX;
			2, 3: slope = {$urandom_range(0, 1), $urandom};
			default: slope = {$urandom, $urandom} & SLOPE_MAX;
		endcase
		case ($urandom_range(0, 4))
			0: frac = 0;
			1: frac = $signed(16'($urandom));
			default: frac = $signed($urandom);
		endcase
		apply_settings(off, $urandom_range(0, 3) != 0, thr, slope, frac);
	endtask

	// Bias samples toward the extremes and the region around plus and minus threshold.
	function automatic logic signed [31:0] pick_sample();
		longint t;
		longint v;
		t = sb.thr_q;
		case ($urandom_range(0, 9))
			0: v = IN_MAX;
			1: v = IN_MIN;
			2: v = t + longint'($urandom_range(0, 2)) - 1;
			3: v = -t - longint'($urandom_range(0, 2)) + 1;
			4, 5: v = t + longint'($urandom) % (IN_MAX - t + 1);
			6, 7: v = -t - longint'($urandom) % (IN_MAX - t + 2);
			default: v = $signed($urandom);
		endcase
		if (v > IN_MAX)
			v = IN_MAX;
		if (v < IN_MIN)
			v = IN_MIN;
		return v[31:0];
	endfunction

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: plain path with zero offset passes samples through.
		push_sample(IN_MAX[31:0]);
		push_sample(IN_MIN[31:0]);
		push_sample(32'sd0);
		push_sample(-32'sd1);

		// Limiter off, largest offsets: saturate high, then low.
		apply_settings(OFFSET_BOUND, 1'b0, IN_MAX, 0, 0);
		push_sample(IN_MIN[31:0]);
		push_sample(IN_MAX[31:0]);
		push_sample(32'sd0);
		apply_settings(-OFFSET_BOUND, 1'b0, IN_MAX, 0, 0);
		push_sample(IN_MIN[31:0]);

		// Positive shift: only samples above the threshold take the slope path.
		apply_settings(0, 1'b1, 64'h4000_0000, 64'h1_8000_0001, 64'h1000_0001);
		push_sample(IN_MAX[31:0]);
		push_sample(32'sh4000_0001);
		push_sample(32'sh4000_0000);
		push_sample(-32'sh7FFF_FFFF);

		// Negative shift: mirror on the low side, with a borrow from the fraction.
		apply_settings(0, 1'b1, 64'h4000_0000, 64'h1_8000_0001, -64'sh1000_0001);
		push_sample(IN_MIN[31:0]);
		push_sample(-32'sh4000_0001);
		push_sample(-32'sh4000_0000);

		// Zero shift fraction: plain offset applies, the request still counts as processed.
		apply_settings(123, 1'b1, 64'h4000_0000, 64'h1_8000_0001, 0);
		push_sample(IN_MAX[31:0]);
		push_sample(IN_MIN[31:0]);

		// Unit slope, tiny shift: a fraction just above full scale must still clip.
		apply_settings(0, 1'b1, 0, ONE_Q32, 1);
		push_sample(IN_MAX[31:0]);
		push_sample(32'sh1234);
		apply_settings(0, 1'b1, 0, ONE_Q32, -1);
		push_sample(IN_MIN[31:0]);
		push_sample(IN_MIN[31:0] + 32'sd1);

		// Largest slope and shift, then largest threshold with the most negative shift.
		apply_settings(0, 1'b1, 0, SLOPE_MAX, 64'h7FFF_FFFF);
		push_sample(IN_MAX[31:0]);
		apply_settings(0, 1'b1, IN_MAX, ONE_Q32 >> 1, -64'sh8000_0000);
		push_sample(IN_MIN[31:0]);

		// Random part: each phase reconfigures, then runs under one idle/stall pattern.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_settings();
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 71;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 71;
				end
				default: begin
					src_idle_pct = 35;
					sink_stall_pct = 35;
				end
			endcase
			repeat (PHASE_REQUESTS)
				push_sample(pick_sample());
		end

		// Wait out the pipeline, then leave time for any stray result.
		drain_results();
		repeat (10) @(posedge clk);
		if (sb.failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
rtl/dcsl_pkg.sv
rtl/dcsl_ifs.sv
rtl/dc_shift_with_peak_limiter.sv
tb/sv/dc_shift_with_peak_limiter_tb.sv
